>>> rtl/spe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_pkg
// Shared constants and types for the sphere / polygon edge test unit.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int CoordWidth  = 16;
    localparam int QueueDepth  = 4;
    localparam int CfgIdxWidth = 2;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_RADIUS   = 2'd3;

    // product schedule of the shared multiplier
    localparam int StepLen  = 0;
    localparam int StepDot  = 3;
    localparam int StepDd   = 6;
    localparam int StepDb   = 9;
    localparam int StepR2   = 12;
    localparam int NumProd  = 13;
    localparam int StepBits = 4;

    typedef struct packed {
        logic set_hit;  // job opens a face: result replaces the running hit
        logic emit;     // job closes a face: deliver the running hit
    } t_job_ctl;

    localparam int CtlWidth = $bits(t_job_ctl);

endpackage

>>> rtl/sphere_polygon_edge_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_polygon_edge_test_unit
// Streams polygon vertices and reports whether any edge or vertex of each
// closed face touches a configured sphere.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  vertex    i_in_valid / o_in_ready, vertex, flags   in
//  result    o_out_valid / i_out_ready, o_face_hit    out
//  config    i_cfg_valid / o_cfg_ready, index, data   in
//
// each vertex makes one edge job, a last vertex a second (closing) job
// a job runs the shared multiplier (13 products), and the bit-serial product
// compare as well when the closest point lies inside the segment and the
// first end of the edge lies outside the sphere
// a four-entry job queue lets vertex intake run ahead of the test engine
// reset is synchronous and clears face state, queue and result; config
// writes are always taken
// ----------------------------------------------------------------------------
module sphere_polygon_edge_test_unit #(
    parameter int COORD_WIDTH = spe_pkg::CoordWidth
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [COORD_WIDTH-1:0]             i_vertex_x,
    input  logic [COORD_WIDTH-1:0]             i_vertex_y,
    input  logic [COORD_WIDTH-1:0]             i_vertex_z,
    input  logic                               i_first_vertex,
    input  logic                               i_last_vertex,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_face_hit,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spe_pkg::CfgIdxWidth-1:0]    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]             i_cfg_data
);
    import spe_pkg::*;

    localparam int JW = 6 * COORD_WIDTH + CtlWidth;

    logic [COORD_WIDTH-1:0] r_center_x, r_center_y, r_center_z;
    logic [COORD_WIDTH-2:0] r_radius;
    logic                   q_push, q_pop, q_full, q_empty;
    logic [JW-1:0]          q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[COORD_WIDTH-2:0];
                default: begin
                end
            endcase
        end
    end

    spe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_vertex      ({i_vertex_x, i_vertex_y, i_vertex_z}),
        .i_first_vertex(i_first_vertex),
        .i_last_vertex (i_last_vertex),
        .o_push        (q_push),
        .o_job         (q_in),
        .i_full        (q_full)
    );

    spe_fifo #(.WIDTH(JW), .DEPTH(QueueDepth)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    spe_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_job      (q_out),
        .o_pop      (q_pop),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_radius   (r_radius),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_face_hit (o_face_hit)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("job queue underflow");

    a_intake_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !o_in_ready)
        else $error("vertex taken while job queue full");

    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

>>> rtl/spe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_fifo
// Small register queue of edge jobs between the front and the back.
// ----------------------------------------------------------------------------
module spe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/spe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_front
// Accepts vertices, tracks first and prior vertex, and issues edge jobs.
// ----------------------------------------------------------------------------
module spe_front #(
    parameter int COORD_WIDTH = spe_pkg::CoordWidth
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [3*COORD_WIDTH-1:0]               i_vertex,
    input  logic                                   i_first_vertex,
    input  logic                                   i_last_vertex,
    output logic                                   o_push,
    output logic [6*COORD_WIDTH+spe_pkg::CtlWidth-1:0] o_job,
    input  logic                                   i_full
);
    import spe_pkg::*;

    localparam int VW = 3 * COORD_WIDTH;
    localparam int JW = 2 * VW + CtlWidth;

    logic [VW-1:0] r_start, r_prior, n_start;
    logic          r_pend_vld;
    logic [JW-1:0] r_pend;
    logic          accept;
    t_job_ctl      ctl_edge, ctl_close;
    logic [VW-1:0] edge_a;

    assign o_in_ready = !r_pend_vld && !i_full;
    assign accept     = i_in_valid && o_in_ready;

    // a first vertex is tested as a zero-length edge onto itself
    assign edge_a  = i_first_vertex ? i_vertex : r_prior;
    assign n_start = i_first_vertex ? i_vertex : r_start;

    always_comb begin
        ctl_edge.set_hit  = i_first_vertex;
        ctl_edge.emit     = 1'b0;
        ctl_close.set_hit = 1'b0;
        ctl_close.emit    = 1'b1;
    end

    assign o_push = accept || (r_pend_vld && !i_full);
    assign o_job  = r_pend_vld ? r_pend : {edge_a, i_vertex, ctl_edge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_prior    <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_start <= n_start;
                r_prior <= i_vertex;
                if (i_last_vertex) begin
                    r_pend_vld <= 1'b1;
                end
            end else if (r_pend_vld && !i_full) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    // closing edge from the last vertex back to the first
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= {i_vertex, n_start, ctl_close};
        end
    end

endmodule

>>> rtl/spe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_back
// Runs one edge-versus-sphere test per job on a shared multiplier and a
// bit-serial compare, keeps the running face hit and drives the result.
// ----------------------------------------------------------------------------
module spe_back #(
    parameter int COORD_WIDTH = spe_pkg::CoordWidth
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_empty,
    input  logic [6*COORD_WIDTH+spe_pkg::CtlWidth-1:0] i_job,
    output logic                                   o_pop,
    input  logic [COORD_WIDTH-1:0]                 i_center_x,
    input  logic [COORD_WIDTH-1:0]                 i_center_y,
    input  logic [COORD_WIDTH-1:0]                 i_center_z,
    input  logic [COORD_WIDTH-2:0]                 i_radius,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_face_hit
);
    import spe_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int VW  = 3 * W;
    localparam int MW  = W + 1;
    localparam int PW  = 2 * MW;
    localparam int SW  = 2 * W + 4;
    localparam int AW  = 2 * SW + 1;
    localparam int CW  = $clog2(SW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_SER  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]    r_state;
    logic [VW-1:0] r_a, r_b;
    t_job_ctl      r_ctl;
    logic [MW-1:0] r_dm [3];
    logic [MW-1:0] r_em [3];
    logic [MW-1:0] r_bm [3];
    logic [2:0]    r_dneg;
    logic [StepBits-1:0] r_k, r_pk;
    logic          r_pv;
    logic [PW-1:0] r_prod;
    logic [SW-1:0] r_len, r_pos, r_neg, r_dd, r_db, r_r2;
    logic [AW-1:0] r_acc, r_sm, r_sd, n_acc;
    logic [SW-1:0] r_sl, r_sq;
    logic [CW-1:0] r_cnt;
    logic          r_res, r_hit;
    logic          r_out_vld, r_out_hit;

    logic [W-1:0]  ca [3];
    logic [W-1:0]  av [3];
    logic [W-1:0]  bv [3];
    logic [MW-1:0] dif_d [3];
    logic [MW-1:0] dif_e [3];
    logic [MW-1:0] dif_b [3];
    logic [MW-1:0] op_x, op_y;
    logic [1:0]    sub_k, sub_pk;
    logic [SW-1:0] prod_x;
    logic          len_zero, back_side, far_side, dd_in, db_in, hit_now;
    logic [SW:0]   len_neg;

    function automatic logic [MW-1:0] mag_of(input logic [MW-1:0] v);
        return v[MW-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        ca[0] = i_center_x;
        ca[1] = i_center_y;
        ca[2] = i_center_z;
        for (int i = 0; i < 3; i++) begin
            av[i]    = r_a[VW-1-i*W -: W];
            bv[i]    = r_b[VW-1-i*W -: W];
            dif_d[i] = {ca[i][W-1], ca[i]} - {av[i][W-1], av[i]};
            dif_e[i] = {bv[i][W-1], bv[i]} - {av[i][W-1], av[i]};
            dif_b[i] = {ca[i][W-1], ca[i]} - {bv[i][W-1], bv[i]};
        end
    end

    // multiplier operand schedule
    always_comb begin
        op_x  = '0;
        op_y  = '0;
        sub_k = '0;
        case (r_k) inside
            [StepBits'(StepLen):StepBits'(StepLen + 2)]: begin
                sub_k = 2'(r_k - StepBits'(StepLen));
                op_x  = r_em[sub_k];
                op_y  = r_em[sub_k];
            end
            [StepBits'(StepDot):StepBits'(StepDot + 2)]: begin
                sub_k = 2'(r_k - StepBits'(StepDot));
                op_x  = r_dm[sub_k];
                op_y  = r_em[sub_k];
            end
            [StepBits'(StepDd):StepBits'(StepDd + 2)]: begin
                sub_k = 2'(r_k - StepBits'(StepDd));
                op_x  = r_dm[sub_k];
                op_y  = r_dm[sub_k];
            end
            [StepBits'(StepDb):StepBits'(StepDb + 2)]: begin
                sub_k = 2'(r_k - StepBits'(StepDb));
                op_x  = r_bm[sub_k];
                op_y  = r_bm[sub_k];
            end
            StepBits'(StepR2): begin
                op_x = {2'b00, i_radius};
                op_y = {2'b00, i_radius};
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    assign prod_x = {{(SW-PW){1'b0}}, r_prod};
    assign sub_pk = 2'(r_pk - StepBits'(StepDot));

    always_comb begin
        len_zero  = (r_len == '0);
        back_side = (r_pos <= r_neg);
        len_neg   = {1'b0, r_len} + {1'b0, r_neg};
        far_side  = ({1'b0, r_pos} >= len_neg);
        dd_in     = (r_dd <= r_r2);
        db_in     = (r_db <= r_r2);
        n_acc     = r_acc + (r_sl[0] ? r_sm : '0) - (r_sq[0] ? r_sd : '0);
        hit_now   = r_ctl.set_hit ? r_res : (r_hit | r_res);
    end

    assign o_pop       = (r_state == ST_IDLE) && !i_empty;
    assign o_out_valid = r_out_vld;
    assign o_face_hit  = r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
            r_k       <= '0;
            r_pv      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if ((r_state == ST_DONE) && r_ctl.emit && (!r_out_vld || i_out_ready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_k     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_k == StepBits'(NumProd)) begin
                        r_pv    <= 1'b0;
                        r_state <= ST_DEC;
                    end else begin
                        r_pv <= 1'b1;
                        r_k  <= r_k + 1'b1;
                    end
                end
                ST_DEC: begin
                    r_cnt <= '0;
                    if (len_zero || back_side || far_side || dd_in) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SER;
                    end
                end
                ST_SER: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SW - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_ctl.emit) begin
                        r_hit   <= hit_now;
                        r_state <= ST_IDLE;
                    end else if (!r_out_vld || i_out_ready) begin
                        r_hit     <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a   <= i_job[2*VW+CtlWidth-1 -: VW];
            r_b   <= i_job[VW+CtlWidth-1 -: VW];
            r_ctl <= i_job[CtlWidth-1:0];
        end
        if (r_state == ST_DIFF) begin
            for (int i = 0; i < 3; i++) begin
                r_dm[i] <= mag_of(dif_d[i]);
                r_em[i] <= mag_of(dif_e[i]);
                r_bm[i] <= mag_of(dif_b[i]);
                r_dneg[i] <= dif_d[i][MW-1] ^ dif_e[i][MW-1];
            end
            r_len <= '0;
            r_pos <= '0;
            r_neg <= '0;
            r_dd  <= '0;
            r_db  <= '0;
            r_r2  <= '0;
        end
        if (r_state == ST_MUL) begin
            r_prod <= op_x * op_y;
            r_pk   <= r_k;
            if (r_pv) begin
                case (r_pk) inside
                    [StepBits'(StepLen):StepBits'(StepLen + 2)]: r_len <= r_len + prod_x;
                    [StepBits'(StepDot):StepBits'(StepDot + 2)]: begin
                        if (r_dneg[sub_pk]) begin
                            r_neg <= r_neg + prod_x;
                        end else begin
                            r_pos <= r_pos + prod_x;
                        end
                    end
                    [StepBits'(StepDd):StepBits'(StepDd + 2)]: r_dd <= r_dd + prod_x;
                    [StepBits'(StepDb):StepBits'(StepDb + 2)]: r_db <= r_db + prod_x;
                    default: r_r2 <= prod_x;
                endcase
            end
        end
        if (r_state == ST_DEC) begin
            // (dd - r2) * len <= dot^2 decides the interior case
            r_acc <= '0;
            r_sm  <= {{(AW-SW){1'b0}}, r_dd - r_r2};
            r_sd  <= {{(AW-SW){1'b0}}, r_pos - r_neg};
            r_sl  <= r_len;
            r_sq  <= r_pos - r_neg;
            if (len_zero || back_side) begin
                r_res <= dd_in;
            end else if (far_side) begin
                r_res <= db_in;
            end else begin
                r_res <= dd_in;
            end
        end
        if (r_state == ST_SER) begin
            r_acc <= n_acc;
            r_sm  <= r_sm << 1;
            r_sd  <= r_sd << 1;
            r_sl  <= r_sl >> 1;
            r_sq  <= r_sq >> 1;
            if (r_cnt == CW'(SW - 1)) begin
                r_res <= n_acc[AW-1] || (n_acc == '0);
            end
        end
        if ((r_state == ST_DONE) && r_ctl.emit && (!r_out_vld || i_out_ready)) begin
            r_out_hit <= hit_now;
        end
    end

endmodule

>>> tb/sv/sphere_polygon_edge_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_polygon_edge_test_unit_tb
// Streams polygon faces through the unit under several sphere settings.
// A behavioral face-hit predictor computes the expected flag for every closed
// face. The result channel is checked in order against those flags. Both
// channels see random gaps and one long result stall.
// ----------------------------------------------------------------------------
module sphere_polygon_edge_test_unit_tb;
    import spe_pkg::*;

    localparam int CW         = CoordWidth;
    localparam int DrainWait  = 300;
    localparam int WatchLimit = 5000;
    localparam int PhaseItems = 140;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 first;
        logic                 last;
    } vtx_beat_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CW-1:0]        i_vertex_x;
    logic [CW-1:0]        i_vertex_y;
    logic [CW-1:0]        i_vertex_z;
    logic                 i_first_vertex;
    logic                 i_last_vertex;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_face_hit;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CfgIdxWidth-1:0] i_cfg_index;
    logic [CW-1:0]        i_cfg_data;

    sphere_polygon_edge_test_unit dut (.*);

    // predictor state
    longint    sph_cx, sph_cy, sph_cz, sph_rad;
    vtx_beat_t face_start, face_prior;
    bit        face_hit_acc;
    bit        face_hit_q[$];

    vtx_beat_t vertex_q[$];
    int        errors;
    int        faces_checked;
    int        gap_left;
    int        stall_left;
    bit        stall_done;
    bit        ready_busy;
    bit        in_fire;
    int        quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint dist2(vtx_beat_t p);
        longint dx, dy, dz;
        dx = sph_cx - longint'(p.x);
        dy = sph_cy - longint'(p.y);
        dz = sph_cz - longint'(p.z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic bit point_touch(vtx_beat_t p);
        return dist2(p) <= sph_rad * sph_rad;
    endfunction

    // closest point on segment a-b, compared without division
    function automatic bit edge_touch(vtx_beat_t a, vtx_beat_t b);
        longint dx, dy, dz, ex, ey, ez, len, dot, dd, r2;
        logic [127:0] lhs, rhs;
        dx = sph_cx - longint'(a.x);
        dy = sph_cy - longint'(a.y);
        dz = sph_cz - longint'(a.z);
        ex = longint'(b.x) - longint'(a.x);
        ey = longint'(b.y) - longint'(a.y);
        ez = longint'(b.z) - longint'(a.z);
        len = ex * ex + ey * ey + ez * ez;
        dot = dx * ex + dy * ey + dz * ez;
        dd  = dx * dx + dy * dy + dz * dz;
        r2  = sph_rad * sph_rad;
        if (len == 0 || dot <= 0) return dd <= r2;
        if (dot >= len) return point_touch(b);
        lhs = 128'(dd) * 128'(len);
        rhs = 128'(r2) * 128'(len) + 128'(dot) * 128'(dot);
        return lhs <= rhs;
    endfunction

    function automatic void face_step(vtx_beat_t v);
        if (v.first) begin
            face_start   = v;
            face_hit_acc = point_touch(v);
        end else if (edge_touch(face_prior, v)) begin
            face_hit_acc = 1'b1;
        end
        face_prior = v;
        if (v.last) begin
            if (edge_touch(v, face_start)) face_hit_acc = 1'b1;
            face_hit_q.push_back(face_hit_acc);
            face_hit_acc = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CW-1:0] near_coord(longint c);
        int span;
        span = int'(sph_rad) + 50;
        return CW'(c + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic void push_vtx(longint x, longint y, longint z, bit f, bit l);
        vtx_beat_t v;
        v.x = CW'(x); v.y = CW'(y); v.z = CW'(z);
        v.first = f; v.last = l;
        vertex_q.push_back(v);
    endfunction

    // mostly well-formed faces, some loose or broken flag sequences
    task automatic queue_random(int count);
        int n, k, kind;
        vtx_beat_t v;
        while (count > 0) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                v.x     = CW'($urandom);
                v.y     = CW'($urandom);
                v.z     = CW'($urandom);
                v.first = 1'($urandom_range(0, 1));
                v.last  = 1'($urandom_range(0, 1));
                vertex_q.push_back(v);
                count--;
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                 : $urandom_range(1, 5);
                for (k = 0; k < n; k++) begin
                    if (kind < 5) begin
                        v.x = near_coord(sph_cx);
                        v.y = near_coord(sph_cy);
                        v.z = near_coord(sph_cz);
                    end else begin
                        v.x = CW'($urandom);
                        v.y = CW'($urandom);
                        v.z = CW'($urandom);
                    end
                    // occasional repeated vertex gives a zero-length edge
                    if (k > 0 && $urandom_range(0, 11) == 0) v = vertex_q[$];
                    v.first = (k == 0);
                    v.last  = (k == n - 1);
                    vertex_q.push_back(v);
                end
                count -= n;
            end
        end
    endtask

    task automatic cfg_write(logic [CfgIdxWidth-1:0] idx, logic [CW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy,
                              logic [CW-1:0] cz, logic [CW-1:0] rad);
        cfg_write(CFG_CENTER_X, cx);
        cfg_write(CFG_CENTER_Y, cy);
        cfg_write(CFG_CENTER_Z, cz);
        cfg_write(CFG_RADIUS, rad);
    endtask

    // sender pauses until every face flag is back and the engine is quiet
    task automatic drain();
        forever begin
            @(posedge i_clk);
            if (vertex_q.size() == 0 && !i_in_valid && face_hit_q.size() == 0) break;
        end
        repeat (DrainWait) @(posedge i_clk);
    endtask

    // accepted beats feed the predictor
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (in_fire)
            face_step({i_vertex_x, i_vertex_y, i_vertex_z, i_first_vertex, i_last_vertex});
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CENTER_X: sph_cx = longint'(signed'(i_cfg_data));
                CFG_CENTER_Y: sph_cy = longint'(signed'(i_cfg_data));
                CFG_CENTER_Z: sph_cz = longint'(signed'(i_cfg_data));
                CFG_RADIUS:   sph_rad = longint'(i_cfg_data[CW-2:0]);
                default: ;
            endcase
        end
    end

    // vertex driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (vertex_q.size() > 0) begin
                vtx_beat_t v;
                v = vertex_q.pop_front();
                i_vertex_x     <= v.x;
                i_vertex_y     <= v.y;
                i_vertex_z     <= v.z;
                i_first_vertex <= v.first;
                i_last_vertex  <= v.last;
                i_in_valid     <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver with random back-pressure and one long hold-off
    always @(negedge i_clk) begin
        if (!stall_done && faces_checked == 30) begin
            stall_done = 1'b1;
            stall_left = 400;
        end
        if ($urandom_range(0, 149) == 0) ready_busy = ~ready_busy;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (ready_busy) begin
            i_out_ready <= ($urandom_range(0, 99) < 60);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (face_hit_q.size() == 0) begin
                $display("%0t: face_hit beat with nothing expected, actual %0b",
                         $time, o_face_hit);
                errors++;
            end else begin
                bit exp_hit;
                exp_hit = face_hit_q.pop_front();
                if (o_face_hit !== exp_hit) begin
                    $display("%0t: face_hit mismatch, expected %0b actual %0b",
                             $time, exp_hit, o_face_hit);
                    errors++;
                end
            end
            faces_checked++;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_vertex_x     = '0;
        i_vertex_y     = '0;
        i_vertex_z     = '0;
        i_first_vertex = 1'b0;
        i_last_vertex  = 1'b0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        sph_cx = 0; sph_cy = 0; sph_cz = 0; sph_rad = 0;
        face_start = '0; face_prior = '0; face_hit_acc = 1'b0;
        errors = 0; faces_checked = 0; gap_left = 0; stall_left = 0;
        stall_done = 1'b0; ready_busy = 1'b0; in_fire = 1'b0; quiet_cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset sphere: radius zero at the origin, edge from the origin prior
        push_vtx(0, 0, 0, 0, 0);
        push_vtx(-10, 0, 0, 0, 0);
        push_vtx(10, 0, 0, 0, 1);
        push_vtx(5, 5, 5, 1, 1);
        drain();

        set_sphere(16'sd100, -16'sd200, 16'sd300, 16'd500);
        push_vtx(100, -200, 300, 1, 1);            // single-vertex face at center
        push_vtx(32767, 32767, 32767, 1, 1);       // single-vertex face far away
        push_vtx(-5000, -200, 300, 1, 0);          // edge through the sphere
        push_vtx(5000, -200, 300, 0, 1);
        push_vtx(-5000, 5000, 300, 1, 0);          // triangle missing the sphere
        push_vtx(5000, 5000, 300, 0, 0);
        push_vtx(5000, 5000, 300, 0, 0);           // zero-length edge
        push_vtx(0, 9000, 300, 0, 1);
        push_vtx(600, -200, 300, 1, 0);            // vertex exactly on the surface
        push_vtx(900, -200, 300, 0, 1);
        push_vtx(100, -200, 800, 0, 1);            // continues a closed face
        push_vtx(-32768, -32768, -32768, 1, 0);
        push_vtx(32767, 32767, 32767, 0, 1);       // diagonal through the sphere
        push_vtx(-32768, 32767, -32768, 0, 0);     // no first flag after a result
        push_vtx(100, 32767, 300, 0, 1);           // closing edge misses the sphere
        drain();

        set_sphere(16'h8000, 16'h7fff, 16'h8000, 16'hffff);
        push_vtx(-32768, 32767, -32768, 1, 1);
        push_vtx(32767, -32768, 32767, 1, 0);
        push_vtx(32767, -32768, -32768, 0, 1);
        queue_random(PhaseItems);
        drain();

        set_sphere(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        queue_random(PhaseItems);
        drain();

        set_sphere(16'sd0, 16'sd0, 16'sd0, 16'h8000);
        queue_random(PhaseItems / 2);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_sphere(CW'($urandom), CW'($urandom), CW'($urandom),
                       CW'($urandom_range(0, 4000)) | (CW'($urandom) & 16'h8000));
            queue_random(PhaseItems);
            drain();
        end

        if (errors == 0 && face_hit_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
